>>> hw/rtl/ftr_pkg.sv
// ----------------------------------------------------------------------------
// ftr_pkg: shared types and constants of the FSK tape receiver
// Word formats of the input, result and configuration channels, plus the
// sizing constants of the interval ring and the UART framer.
// ----------------------------------------------------------------------------
package ftr_pkg;

  // Number of edge intervals averaged in the ring.
  localparam int unsigned AVG_LEN = 5;
  // Width of the free-running microsecond timestamp.
  localparam int unsigned TIME_W  = 32;
  // Width of a configuration register.
  localparam int unsigned CFG_W   = 16;
  // Width of the running sum of the ring.
  localparam int unsigned SUM_W   = TIME_W + $clog2(AVG_LEN);
  // Width of the ring write pointer.
  localparam int unsigned POS_W   = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
  // Width of the frame bit counter.
  localparam int unsigned IDX_W   = 4;
  // Width of the sampling window bounds.
  localparam int unsigned WIN_W   = CFG_W + IDX_W + 2;
  // Width of the configuration register index.
  localparam int unsigned CIDX_W  = 3;

  // Frame bit counter values.
  localparam logic [IDX_W-1:0] IDX_WAIT_START = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_FIRST_DATA = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_STOP       = IDX_W'(9);

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_BIT_PERIOD = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_ZERO_LOW   = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] REG_ZERO_HIGH  = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] REG_ONE_LOW    = CIDX_W'(3);
  localparam logic [CIDX_W-1:0] REG_ONE_HIGH   = CIDX_W'(4);

  // Configuration register reset values.
  localparam logic [CFG_W-1:0] RST_BIT_PERIOD = CFG_W'(1666);
  localparam logic [CFG_W-1:0] RST_ZERO_LOW   = CFG_W'(90);
  localparam logic [CFG_W-1:0] RST_ZERO_HIGH  = CFG_W'(97);
  localparam logic [CFG_W-1:0] RST_ONE_LOW    = CFG_W'(119);
  localparam logic [CFG_W-1:0] RST_ONE_HIGH   = CFG_W'(130);

  typedef struct packed {
    logic              action;   // 0 signal edge, 1 sample tone bit
    logic [TIME_W-1:0] time_us;
  } ftr_in_t;

  typedef struct packed {
    logic       demod_bit;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       frame_error;
  } ftr_out_t;

endpackage

>>> hw/rtl/fsk_tape_receiver_top.sv
// ----------------------------------------------------------------------------
// fsk_tape_receiver_top: cassette FSK demodulator with a timed UART framer
// Path: an accepted word is held in the input register; its result word then
//   enters the result register (out_*) once that is empty or being emptied.
// Throughput: one word per cycle while results are taken; the state update
//   for one word is a single pass of logic, so the next word always sees it.
// Reset: asynchronous, active low; clears all state and loads register
//   defaults. No clearing pass, the block is ready right after reset.
// ----------------------------------------------------------------------------
module fsk_tape_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ftr_pkg::ftr_in_t              in_data_i,
  // Result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ftr_pkg::ftr_out_t             out_data_o,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ftr_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [ftr_pkg::CFG_W-1:0]     cfg_data_i
);
  import ftr_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are taken at any time; the user is to
  // write only while no word is in flight, which the block does not enforce.
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] bit_period_q, zero_low_q, zero_high_q, one_low_q, one_high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= RST_BIT_PERIOD;
      zero_low_q   <= RST_ZERO_LOW;
      zero_high_q  <= RST_ZERO_HIGH;
      one_low_q    <= RST_ONE_LOW;
      one_high_q   <= RST_ONE_HIGH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BIT_PERIOD: bit_period_q <= cfg_data_i;
        REG_ZERO_LOW:   zero_low_q   <= cfg_data_i;
        REG_ZERO_HIGH:  zero_high_q  <= cfg_data_i;
        REG_ONE_LOW:    one_low_q    <= cfg_data_i;
        REG_ONE_HIGH:   one_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake. The input register advances into the result register
  // whenever the result register is empty or being emptied, so a finished
  // result waiting downstream stalls the input only when the input is full.
  // --------------------------------------------------------------------------
  logic     in_valid_q;
  ftr_in_t  in_q;
  logic     out_valid_q;
  ftr_out_t out_q;
  logic     advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver state.
  // The ring mean is never formed: the running sum S of the ring is kept and
  // each band test on floor(S / AVG_LEN) is turned into a compare of S with
  // the band edge scaled by AVG_LEN. A nonzero mean is S >= AVG_LEN.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] ring_q [AVG_LEN];
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [TIME_W-1:0] prev_q, prev_d;
  logic              held_q, held_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [7:0]        asm_q, asm_d;
  logic              ring_we;
  ftr_out_t          res;

  // Band compares on the running sum.
  logic [SUM_W-1:0]  zero_lo_sum, zero_hi_sum, one_lo_sum, one_hi_sum;
  logic              mean_nz, zero_hit, one_hit, tone;

  assign zero_lo_sum = SUM_W'(AVG_LEN) * (SUM_W'(zero_low_q) + SUM_W'(1));
  assign zero_hi_sum = SUM_W'(AVG_LEN) * SUM_W'(zero_high_q);
  assign one_lo_sum  = SUM_W'(AVG_LEN) * (SUM_W'(one_low_q) + SUM_W'(1));
  assign one_hi_sum  = SUM_W'(AVG_LEN) * SUM_W'(one_high_q);

  assign mean_nz  = (sum_q >= SUM_W'(AVG_LEN));
  assign zero_hit = (sum_q >= zero_lo_sum) && (sum_q < zero_hi_sum);
  assign one_hit  = (sum_q >= one_lo_sum) && (sum_q < one_hi_sum);

  // The one band wins where the bands overlap; outside both the tone holds.
  always_comb begin
    tone = held_q;
    if (zero_hit) begin
      tone = 1'b0;
    end
    if (one_hit) begin
      tone = 1'b1;
    end
  end

  // Sampling window of the current frame bit, from base + period/4 to
  // base + 9*period/4, where base is the bit index times the period.
  logic [TIME_W-1:0] elapsed, interval;
  logic [WIN_W-1:0]  win_base, win_lo, win_hi, period_x9;
  logic              past_lo, before_hi;
  logic [2:0]        bit_sel;

  assign elapsed   = in_q.time_us - start_q;
  assign interval  = in_q.time_us - prev_q;
  assign win_base  = WIN_W'(bit_period_q) * WIN_W'(idx_q);
  assign period_x9 = (WIN_W'(bit_period_q) << 3) + WIN_W'(bit_period_q);
  assign win_lo    = win_base + (WIN_W'(bit_period_q) >> 2);
  assign win_hi    = win_base + (period_x9 >> 2);
  assign past_lo   = (elapsed > TIME_W'(win_lo));
  assign before_hi = (elapsed < TIME_W'(win_hi));
  assign bit_sel   = 3'(idx_q - IDX_FIRST_DATA);

  always_comb begin
    sum_d   = sum_q;
    pos_d   = pos_q;
    prev_d  = prev_q;
    held_d  = held_q;
    idx_d   = idx_q;
    start_d = start_q;
    asm_d   = asm_q;
    ring_we = 1'b0;
    res     = '0;
    if (!in_q.action) begin
      // Edge: replace the oldest interval and keep the sum in step.
      ring_we = 1'b1;
      sum_d   = sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(interval);
      pos_d   = (pos_q == POS_W'(AVG_LEN - 1)) ? '0 : pos_q + POS_W'(1);
      prev_d  = in_q.time_us;
    end else begin
      if (mean_nz) begin
        held_d = tone;
      end
      if (idx_q == IDX_WAIT_START) begin
        // The inverted start bit shows as a one tone.
        if (tone) begin
          idx_d   = IDX_FIRST_DATA;
          asm_d   = '0;
          start_d = in_q.time_us;
        end
      end else if (past_lo) begin
        if (before_hi) begin
          if (idx_q >= IDX_STOP) begin
            res.byte_valid  = 1'b1;
            res.data_byte   = asm_q;
            res.frame_error = tone;
            idx_d           = IDX_WAIT_START;
          end else begin
            if (!tone) begin
              asm_d[bit_sel] = 1'b1;
            end
            idx_d = idx_q + IDX_W'(1);
          end
        end else begin
          // Sample too late for this bit: the frame has slipped.
          idx_d           = IDX_WAIT_START;
          res.frame_error = 1'b1;
        end
      end
    end
    res.demod_bit = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(AVG_LEN); i++) begin
        ring_q[i] <= '0;
      end
      pos_q   <= '0;
      sum_q   <= '0;
      prev_q  <= '0;
      held_q  <= 1'b0;
      idx_q   <= IDX_WAIT_START;
      start_q <= '0;
      asm_q   <= '0;
    end else if (advance) begin
      if (ring_we) begin
        ring_q[pos_q] <= interval;
      end
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      prev_q  <= prev_d;
      held_q  <= held_d;
      idx_q   <= idx_d;
      start_q <= start_d;
      asm_q   <= asm_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_STOP)
    else $error("frame bit counter beyond the stop bit");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(AVG_LEN - 1))
    else $error("ring pointer beyond the ring");

  a_stall_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the result register could drain");

  a_edge_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_q.action) |=> (!out_q.byte_valid && !out_q.frame_error))
    else $error("edge word produced a frame result");

  a_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.byte_valid) |-> (out_data_o.data_byte == 8'd0))
    else $error("data byte nonzero without a completed frame");

endmodule

>>> bench/tb_fsk_tape_receiver_top.sv
// ----------------------------------------------------------------------------
// tb_fsk_tape_receiver_top: self-checking bench for the FSK tape receiver
// Sends edge and sample words through the input channel, rewrites the band
// and bit period registers between phases, and checks every result word
// against a cycle-free model of the demodulator and the UART framer.
// ----------------------------------------------------------------------------
module tb_fsk_tape_receiver_top;
  import ftr_pkg::*;

  // Action codes of an input word.
  localparam logic ACT_EDGE   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam int unsigned MAX_REPORTS  = 10;
  // Result register plus input register, with some margin.
  localparam int unsigned DRAIN_CYCLES = 4;
  // A jump longer than any sampling window, so a half-received frame slips.
  localparam logic [TIME_W-1:0] FLUSH_GAP = 32'd1_000_000;

  // One phase: register values, idle and stall shares and the number of words.
  typedef struct packed {
    logic [CFG_W-1:0] bp;
    logic [CFG_W-1:0] zlo;
    logic [CFG_W-1:0] zhi;
    logic [CFG_W-1:0] olo;
    logic [CFG_W-1:0] ohi;
    int unsigned      idle_pct;
    int unsigned      stall_pct;
    int unsigned      words;
  } phase_cfg_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  ftr_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  ftr_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CIDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_data_i  = '0;

  always #1 clk_i = ~clk_i;

  fsk_tape_receiver_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Words waiting to be driven, results waiting to be seen, and the counters
  // that tell the stimulus process when the block has gone quiet.
  ftr_in_t     word_q[$];
  ftr_out_t    tape_result_q[$];
  int unsigned words_queued    = 0;
  int unsigned words_accepted  = 0;
  int unsigned cfg_writes_done = 0;
  int unsigned mismatches      = 0;
  int unsigned results_seen    = 0;
  logic        word_taken      = 1'b0;
  int unsigned send_idle_pct   = 0;
  int unsigned stall_pct       = 0;

  // Stimulus side: the settings of the current phase and the time cursor.
  phase_cfg_t        ph    = '0;
  logic [TIME_W-1:0] t_now = '0;

  // Model state. It starts at the reset values, since reset is applied once.
  logic [CFG_W-1:0]  cfg_bit_us  = RST_BIT_PERIOD;
  logic [CFG_W-1:0]  cfg_zero_lo = RST_ZERO_LOW;
  logic [CFG_W-1:0]  cfg_zero_hi = RST_ZERO_HIGH;
  logic [CFG_W-1:0]  cfg_one_lo  = RST_ONE_LOW;
  logic [CFG_W-1:0]  cfg_one_hi  = RST_ONE_HIGH;
  logic [TIME_W-1:0] last_edge_us = '0;
  logic [TIME_W-1:0] edge_gaps [AVG_LEN] = '{default: '0};
  int unsigned       gap_wr     = 0;
  logic [TIME_W-1:0] gap_mean   = '0;
  logic              tone_held  = 1'b0;
  logic [IDX_W-1:0]  uart_idx   = IDX_WAIT_START;
  logic [TIME_W-1:0] uart_t0    = '0;
  logic [7:0]        uart_shift = '0;

  // Works out the result word of one accepted input word and advances the
  // model: edge words feed the interval ring, sample words run the framer.
  function automatic ftr_out_t predict_tape_word(input ftr_in_t w);
    ftr_out_t          res;
    logic [63:0]       gap_sum;
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       base;
    logic [63:0]       win_lo;
    logic [63:0]       win_hi;
    logic              tone;
    int                i;
    res = '0;
    if (w.action == ACT_EDGE) begin
      edge_gaps[gap_wr] = w.time_us - last_edge_us;
      gap_wr = (gap_wr == AVG_LEN - 1) ? 0 : gap_wr + 1;
      gap_sum = '0;
      for (i = 0; i < AVG_LEN; i++) begin
        gap_sum += edge_gaps[i];
      end
      gap_mean = TIME_W'(gap_sum / AVG_LEN);
      last_edge_us = w.time_us;
    end else begin
      // A mean of zero, or one outside both bands, keeps the old tone.
      // Where the bands overlap the one band is checked last and wins.
      tone = tone_held;
      if (gap_mean != '0) begin
        if (gap_mean > cfg_zero_lo && gap_mean < cfg_zero_hi) tone = 1'b0;
        if (gap_mean > cfg_one_lo && gap_mean < cfg_one_hi) tone = 1'b1;
        tone_held = tone;
      end
      if (uart_idx == IDX_WAIT_START) begin
        if (tone) begin
          uart_idx   = IDX_FIRST_DATA;
          uart_shift = '0;
          uart_t0    = w.time_us;
        end
      end else begin
        elapsed = w.time_us - uart_t0;
        base    = 64'(cfg_bit_us) * 64'(uart_idx);
        win_lo  = base + 64'(cfg_bit_us) / 4;
        win_hi  = base + (64'(cfg_bit_us) * 9) / 4;
        // Samples before the window are ignored; late ones drop the frame.
        if (64'(elapsed) > win_lo) begin
          if (64'(elapsed) < win_hi) begin
            if (uart_idx >= IDX_STOP) begin
              res.byte_valid  = 1'b1;
              res.data_byte   = uart_shift;
              res.frame_error = tone;
              uart_idx        = IDX_WAIT_START;
            end else begin
              // The line is inverted: a zero tone is a one data bit.
              if (!tone) uart_shift[3'(uart_idx - 1)] = 1'b1;
              uart_idx = uart_idx + IDX_W'(1);
            end
          end else begin
            uart_idx        = IDX_WAIT_START;
            res.frame_error = 1'b1;
          end
        end
      end
    end
    res.demod_bit = tone_held;
    return res;
  endfunction

  task automatic report_miss(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Input driver. A word stays on the port until the edge that takes it;
  // only then may the next one go out, or the line fall idle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= word_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor. Results are checked first, then register writes and new input
  // words update the model, all on the values sampled at this edge.
  always @(posedge clk_i) begin : tape_monitor
    ftr_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (tape_result_q.size() == 0) begin
          report_miss($sformatf("result %0d arrived with nothing expected: %p",
                                results_seen, out_data_o));
        end else begin
          want = tape_result_q.pop_front();
          if (out_data_o.demod_bit !== want.demod_bit ||
              out_data_o.byte_valid !== want.byte_valid ||
              out_data_o.data_byte !== want.data_byte ||
              out_data_o.frame_error !== want.frame_error) begin
            report_miss($sformatf(
              "result %0d mismatch: expected bit=%0b valid=%0b byte=%02h err=%0b, %s",
              results_seen, want.demod_bit, want.byte_valid, want.data_byte,
              want.frame_error,
              $sformatf("got bit=%0b valid=%0b byte=%02h err=%0b",
                        out_data_o.demod_bit, out_data_o.byte_valid,
                        out_data_o.data_byte, out_data_o.frame_error)));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BIT_PERIOD: cfg_bit_us  = cfg_data_i;
          REG_ZERO_LOW:   cfg_zero_lo = cfg_data_i;
          REG_ZERO_HIGH:  cfg_zero_hi = cfg_data_i;
          REG_ONE_LOW:    cfg_one_lo  = cfg_data_i;
          REG_ONE_HIGH:   cfg_one_hi  = cfg_data_i;
          default: ;
        endcase
        cfg_writes_done++;
      end
      if (in_valid_i && in_ready_o) begin
        tape_result_q.push_back(predict_tape_word(in_data_i));
        words_accepted++;
      end
    end
    word_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  task automatic push_word(input logic act, input logic [TIME_W-1:0] t);
    ftr_in_t w;
    w.action  = act;
    w.time_us = t;
    word_q.push_back(w);
    words_queued++;
  endtask

  // Writes one register; the block is idle whenever this is called.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    int unsigned seen;
    seen = cfg_writes_done;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    while (cfg_writes_done == seen) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || tape_result_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Edge spacing that lands inside the band of the wanted tone. When the
  // band is too narrow to hold a value, any modest spacing will do.
  function automatic logic [TIME_W-1:0] tone_interval(input logic tone);
    int unsigned lo;
    int unsigned hi;
    lo = 32'(tone ? ph.olo : ph.zlo);
    hi = 32'(tone ? ph.ohi : ph.zhi);
    if (hi >= lo + 2) return lo + 1 + $urandom_range(hi - lo - 2);
    return $urandom_range(300, 1);
  endfunction

  // Plays a tone up to the given time, then samples it. The edge count is
  // capped so that slow bit periods with short tones stay cheap.
  task automatic send_bit(input logic tone, input logic [TIME_W-1:0] target);
    logic [TIME_W-1:0] iv;
    int unsigned       n;
    n  = 0;
    iv = tone_interval(tone);
    while (n < 16 && (target - t_now) > iv) begin
      t_now += iv;
      push_word(ACT_EDGE, t_now);
      iv = tone_interval(tone);
      n++;
    end
    t_now = target;
    push_word(ACT_SAMPLE, target);
  endtask

  // One frame: an idle zero tone with a long gap to flush the framer, a
  // start bit, eight random data bits and a stop bit. Samples sit near the
  // middle of their windows, now and then at the very edge of one. A
  // nonzero slip_bit puts a late sample on that bit and ends the frame.
  task automatic send_frame(input int unsigned slip_bit);
    logic [TIME_W-1:0] t0;
    longint unsigned   bp;
    longint unsigned   off;
    longint unsigned   win_lo;
    longint unsigned   win_hi;
    logic              tone;
    int unsigned       k;
    int unsigned       pick;
    bp = 64'(ph.bp);
    send_bit(1'b0, t_now + FLUSH_GAP);
    send_bit(1'b1, t_now + 10 * tone_interval(1'b1));
    t0 = t_now;
    for (k = 1; k <= IDX_STOP; k++) begin
      win_lo = k * bp + bp / 4;
      win_hi = k * bp + (9 * bp) / 4;
      // A stop bit on the one tone is the rare bad-stop case.
      tone = (k == IDX_STOP) ? ($urandom_range(9) == 0) : logic'($urandom_range(1));
      if (k == slip_bit) begin
        send_bit(tone, t0 + TIME_W'(win_hi + $urandom_range(bp)));
        return;
      end
      off  = (k + 1) * bp + $urandom_range(bp / 4) - bp / 8;
      pick = $urandom_range(7);
      if (pick == 0) begin
        // Right on the window start, which does not count yet.
        send_bit(tone, t0 + TIME_W'(win_lo));
        off = win_lo + 1;
      end else if (pick == 1 && k == IDX_STOP) begin
        off = win_hi - 1;
      end
      send_bit(tone, t0 + TIME_W'(off));
    end
  endtask

  // A short burst of edges and samples at odd times, some fully random.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(8, 1);
    repeat (n) begin
      if ($urandom_range(3) == 0) t_now = $urandom();
      else t_now += $urandom_range(2 * ph.bp + 200);
      push_word(logic'($urandom_range(1)), t_now);
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned goal;
    int unsigned r;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset settings. A sample before any edge sees a
    // zero mean and holds the tone. The first edge gives the longest
    // possible interval, the next one wraps the timestamp.
    push_word(ACT_SAMPLE, '0);
    push_word(ACT_EDGE, '1);
    t_now = 32'h10;
    push_word(ACT_EDGE, t_now);
    // A mean equal to the one band's low bound is outside the band.
    repeat (AVG_LEN) begin
      t_now += RST_ONE_LOW;
      push_word(ACT_EDGE, t_now);
    end
    push_word(ACT_SAMPLE, t_now);
    // A clean one tone starts a frame.
    repeat (AVG_LEN) begin
      t_now += 124;
      push_word(ACT_EDGE, t_now);
    end
    push_word(ACT_SAMPLE, t_now);
    // Exactly at the first window start: ignored. One later: first data bit.
    push_word(ACT_SAMPLE, t_now + RST_BIT_PERIOD + RST_BIT_PERIOD / 4);
    push_word(ACT_SAMPLE, t_now + RST_BIT_PERIOD + RST_BIT_PERIOD / 4 + 1);
    // Exactly at the end of the second window: a bit slip.
    t_now += 2 * RST_BIT_PERIOD + (9 * RST_BIT_PERIOD) / 4;
    push_word(ACT_SAMPLE, t_now);
    wait_drained();

    // Random phases. Each rewrites every register while the block is idle,
    // and the sender holds off at the end until every result is back.
    for (p = 0; p < 7; p++) begin
      case (p)
        0: ph = '{16'd1666, 16'd90, 16'd97, 16'd119, 16'd130, 0, 0, 150};
        1: ph = '{16'd1100, 16'd90, 16'd97, 16'd119, 16'd130, 86, 0, 100};
        2: ph = '{16'd65535, 16'd6000, 16'd6100, 16'd7200, 16'd7300, 0, 86, 120};
        // Both bands cover the same range, so the one band always wins there.
        3: ph = '{16'd1, 16'd0, 16'd65535, 16'd0, 16'd65535, 22, 22, 60};
        // Empty zero band and a zero bit period: every late sample slips.
        4: ph = '{16'd0, 16'd65535, 16'd0, 16'd300, 16'd400, 0, 86, 40};
        5: ph = '{16'd2000, 16'd150, 16'd170, 16'd210, 16'd230, 22, 22, 100};
        default: ph = '{16'd900, 16'd50, 16'd60, 16'd95, 16'd105, 86, 0, 130};
      endcase
      write_reg(REG_BIT_PERIOD, ph.bp);
      write_reg(REG_ZERO_LOW, ph.zlo);
      write_reg(REG_ZERO_HIGH, ph.zhi);
      write_reg(REG_ONE_LOW, ph.olo);
      write_reg(REG_ONE_HIGH, ph.ohi);
      send_idle_pct = ph.idle_pct;
      stall_pct     = ph.stall_pct;
      // Start one phase just below the wrap point of the timestamp.
      if (p == 5) t_now = 32'hFFFF_0000;
      goal = words_queued + ph.words;
      while (words_queued < goal) begin
        r = $urandom_range(99);
        if (r < 70) send_frame(0);
        else if (r < 85) send_noise();
        else send_frame($urandom_range(IDX_STOP, 1));
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a stalled handshake or a lost result ends the run here.
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ftr_pkg.sv
hw/rtl/fsk_tape_receiver_top.sv
bench/tb_fsk_tape_receiver_top.sv
